[src/mctd_pkg.sv]
// Package: shared types, constants and codes for the task dispatcher.
`default_nettype none
package mctd_pkg;

  localparam int CpuCountDef   = 8;
  localparam int QueueDepthDef = 16;
  localparam int TimeBitsDef   = 32;

  localparam logic [0:0] OpArrival   = 1'b0;
  localparam logic [0:0] OpDeparture = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StIdleDep  = 2'd2;
  localparam logic [1:0] StBadCpu   = 2'd3;

  localparam logic [0:0] RegMode   = 1'b0;
  localparam logic [0:0] RegActive = 1'b1;

  localparam logic [47:0] Acc48Max = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [31:0] event_time;
    logic [15:0] task_id;
    logic [31:0] svc_ticks;
    logic [2:0]  target_cpu;
    logic [2:0]  cpu_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        started;
    logic [2:0]  start_cpu;
    logic [15:0] start_task;
    logic [32:0] departure_due;
    logic [31:0] completed_total;
    logic [47:0] turnaround_total;
    logic [47:0] busy_total;
    logic [63:0] queue_area;
    logic [7:0]  waiting_now;
  } out_item_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkEmit
  } bk_state_t;

endpackage
`default_nettype wire

[src/mctd_if.sv]
// Interface: valid/ready channel carrying one payload beat.
`default_nettype none
interface mctd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/mctd_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module mctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[src/mctd_front.sv]
// Front end: two-entry input queue toward the back end.
`default_nettype none
module mctd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  mctd_if.sink                     in_ch,
  output logic                     q_valid,
  output mctd_pkg::in_item_t       q_item,
  input  wire logic                q_pop
);
  mctd_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
    end
    if (push) buf_r[wr_r] <= in_ch.data;
  end
endmodule
`default_nettype wire

[src/mctd_back.sv]
// Back end: runs one event against CPU, FIFO and accumulator state.
`default_nettype none
module mctd_back #(
  parameter int QUEUE_DEPTH = mctd_pkg::QueueDepthDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mode,
  input  wire logic [3:0]    active,
  input  wire logic          q_valid,
  input  mctd_pkg::in_item_t q_item,
  output logic               q_pop,
  mctd_if.source             out_ch,
  output logic               idle
);
  localparam int CPU_COUNT = mctd_pkg::CpuCountDef;
  localparam int TIME_BITS = mctd_pkg::TimeBitsDef;
  localparam int QC  = CPU_COUNT + 1;
  localparam int QB  = $clog2(QC);
  localparam int CB  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int DB  = $clog2(QUEUE_DEPTH);
  localparam int FB  = $clog2(QUEUE_DEPTH + 1);
  localparam int MD  = QC * QUEUE_DEPTH;
  localparam int MB  = $clog2(MD);
  localparam int EW  = 16 + 2 * TIME_BITS;
  localparam int WB  = $clog2(MD + 1);
  localparam logic [QB-1:0] SharedQ = QB'(CPU_COUNT);

  mctd_pkg::bk_state_t st_r, st_nxt;
  logic [CPU_COUNT-1:0]  busy_r;
  logic [TIME_BITS-1:0]  rarr_r  [CPU_COUNT];
  logic [TIME_BITS-1:0]  rsvc_r  [CPU_COUNT];
  logic [DB-1:0]         head_r  [QC];
  logic [FB-1:0]         fill_r  [QC];
  logic [WB-1:0]         wait_r;
  logic [TIME_BITS-1:0]  prev_r;
  logic [31:0]           comp_r;
  logic [47:0]           ta_r, busy_acc_r;
  logic [63:0]           area_r;
  logic [63:0]           prod_r;
  mctd_pkg::out_item_t   res_r;
  logic                  ovalid_r;

  // decoded event, held in BkRead
  logic [TIME_BITS-1:0] now;
  logic [3:0]  n_use;
  logic [CB-1:0] tgt, cid, found;
  logic        found_ok, tgt_bad, cid_bad;
  logic [QB-1:0] q_sel;
  logic        do_push, do_pop, do_start_new, do_retire;
  logic [MB-1:0] wr_addr, rd_addr;
  logic [EW-1:0] rd_data;
  logic [TIME_BITS-1:0] dt;

  assign now   = q_item.event_time[TIME_BITS-1:0];
  assign n_use = (active == 4'd0) ? 4'd1 :
                 ({28'd0, active} > CPU_COUNT) ? 4'(CPU_COUNT) : active;
  assign tgt   = CB'(q_item.target_cpu);
  assign cid   = CB'(q_item.cpu_index);
  assign tgt_bad = {1'b0, q_item.target_cpu} >= n_use;
  assign cid_bad = {1'b0, q_item.cpu_index} >= n_use;

  always_comb begin
    found    = '0;
    found_ok = 1'b0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (!busy_r[i] && (i < int'(n_use))) begin
        found    = CB'(i);
        found_ok = 1'b1;
      end
    end
  end

  // read address: head of selected FIFO for a departure
  always_comb begin
    q_sel = mode ? SharedQ : QB'(cid);
    if (q_item.opcode == mctd_pkg::OpArrival && !mode) q_sel = QB'(tgt);
    if (q_item.opcode == mctd_pkg::OpArrival && mode) q_sel = SharedQ;
  end

  logic [DB:0] pos;
  assign pos = {1'b0, head_r[q_sel]} + fill_r[q_sel][DB:0];
  assign rd_addr = MB'(q_sel) * MB'(QUEUE_DEPTH) + MB'(head_r[q_sel]);
  assign wr_addr = MB'(q_sel) * MB'(QUEUE_DEPTH) +
                   MB'((pos >= (DB+1)'(QUEUE_DEPTH)) ? pos - (DB+1)'(QUEUE_DEPTH) : pos);

  mctd_ram #(.WIDTH(EW), .DEPTH(MD)) u_qram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (wr_addr),
    .wr_data ({q_item.task_id, q_item.svc_ticks[TIME_BITS-1:0], now}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // decisions evaluated in BkEmit on the held item (same as q_item: not yet popped)
  logic arr_start, arr_bad, arr_full, dep_ok;
  logic [CB-1:0] arr_cpu;
  always_comb begin
    arr_bad   = !mode && tgt_bad;
    arr_cpu   = mode ? found : tgt;
    arr_start = !arr_bad && (mode ? found_ok : !busy_r[tgt]);
    arr_full  = fill_r[q_sel] >= FB'(QUEUE_DEPTH);
    dep_ok    = !cid_bad && busy_r[cid];
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_start_new = 1'b0;
    do_retire = 1'b0;
    if (st_r == mctd_pkg::BkEmit) begin
      if (q_item.opcode == mctd_pkg::OpArrival) begin
        do_start_new = arr_start;
        do_push      = !arr_bad && !arr_start && !arr_full;
      end else begin
        do_retire = dep_ok;
        do_pop    = dep_ok && (fill_r[q_sel] != '0);
      end
    end
  end

  // FSM: Idle -> Read (compute area product, RAM read) -> Emit
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mctd_pkg::BkIdle: if (q_valid && !ovalid_r) st_nxt = mctd_pkg::BkRead;
      mctd_pkg::BkRead: st_nxt = mctd_pkg::BkEmit;
      mctd_pkg::BkEmit: st_nxt = mctd_pkg::BkIdle;
      default:          st_nxt = mctd_pkg::BkIdle;
    endcase
  end

  always_comb begin
    q_pop = (st_r == mctd_pkg::BkEmit);
    idle  = (st_r == mctd_pkg::BkIdle) && !q_valid && !ovalid_r;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  // waiting count for the area term in the current mode
  logic [WB-1:0] mw;
  always_comb begin
    mw = '0;
    if (mode) mw = WB'(fill_r[CPU_COUNT]);
    else for (int i = 0; i < CPU_COUNT; i++) mw = mw + WB'(fill_r[i]);
  end
  assign dt = (now > prev_r) ? now - prev_r : '0;

  // product is only as wide as count times elapsed ticks
  logic [WB+TIME_BITS-1:0] prod_w;
  assign prod_w = (WB+TIME_BITS)'(mw) * (WB+TIME_BITS)'(dt);

  logic [64:0] area_sum;
  logic [48:0] ta_sum, bs_sum;
  logic [TIME_BITS-1:0] ta_d;
  logic [TIME_BITS:0] due;
  logic [WB-1:0] wait_n;
  mctd_pkg::out_item_t r;
  logic [47:0] ta_n, bs_n;
  logic [31:0] comp_n;
  always_comb begin
    area_sum = {1'b0, area_r} + {1'b0, prod_r};
    ta_d = (now > rarr_r[cid]) ? now - rarr_r[cid] : '0;
    ta_sum = {1'b0, ta_r} + 49'(ta_d);
    bs_sum = {1'b0, busy_acc_r} + 49'(rsvc_r[cid]);
    ta_n = ta_r; bs_n = busy_acc_r; comp_n = comp_r;
    if (do_retire) begin
      ta_n = ta_sum[48] ? mctd_pkg::Acc48Max : ta_sum[47:0];
      bs_n = bs_sum[48] ? mctd_pkg::Acc48Max : bs_sum[47:0];
      if (comp_r != 32'hFFFF_FFFF) comp_n = comp_r + 32'd1;
    end
    wait_n = wait_r + WB'(do_push) - WB'(do_pop);
    r = '0;
    if (q_item.opcode == mctd_pkg::OpArrival) begin
      if (arr_bad) r.status = mctd_pkg::StBadCpu;
      else if (!arr_start && arr_full) r.status = mctd_pkg::StFull;
    end else begin
      if (cid_bad) r.status = mctd_pkg::StBadCpu;
      else if (!busy_r[cid]) r.status = mctd_pkg::StIdleDep;
    end
    due = {1'b0, now} + {1'b0, do_pop ? rd_data[2*TIME_BITS-1:TIME_BITS] :
                                          q_item.svc_ticks[TIME_BITS-1:0]};
    if (do_start_new || do_pop) begin
      r.started       = 1'b1;
      r.start_cpu     = 3'(do_pop ? cid : arr_cpu);
      r.start_task    = do_pop ? rd_data[EW-1 -: 16] : q_item.task_id;
      r.departure_due = 33'(due);
    end
    r.completed_total  = comp_n;
    r.turnaround_total = ta_n;
    r.busy_total       = bs_n;
    r.queue_area       = area_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : area_sum[63:0];
    r.waiting_now      = ({{(32-WB){1'b0}}, wait_n} > 32'd255) ? 8'hFF : 8'(wait_n);
  end

  logic [CB-1:0] st_cpu;
  assign st_cpu = do_pop ? cid : arr_cpu;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= mctd_pkg::BkIdle;
      busy_r     <= '0;
      wait_r     <= '0;
      prev_r     <= '0;
      comp_r     <= '0;
      ta_r       <= '0;
      busy_acc_r <= '0;
      area_r     <= '0;
      ovalid_r   <= 1'b0;
      for (int i = 0; i < QC; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      if (st_r == mctd_pkg::BkEmit) begin
        ovalid_r   <= 1'b1;
        area_r     <= r.queue_area;
        prev_r     <= now;
        comp_r     <= comp_n;
        ta_r       <= ta_n;
        busy_acc_r <= bs_n;
        wait_r     <= wait_n;
        if (do_start_new || do_pop) busy_r[st_cpu] <= 1'b1;
        else if (do_retire) busy_r[cid] <= 1'b0;
        if (do_push) fill_r[q_sel] <= fill_r[q_sel] + FB'(1);
        if (do_pop) begin
          fill_r[q_sel] <= fill_r[q_sel] - FB'(1);
          head_r[q_sel] <= (head_r[q_sel] == DB'(QUEUE_DEPTH - 1)) ? '0
                           : head_r[q_sel] + DB'(1);
        end
      end
    end
    if (st_r == mctd_pkg::BkRead) begin
      prod_r <= 64'(prod_w);
    end
    if (st_r == mctd_pkg::BkEmit) begin
      res_r <= r;
      if (do_start_new || do_pop) begin
        rarr_r[st_cpu]  <= do_pop ? rd_data[TIME_BITS-1:0] : now;
        rsvc_r[st_cpu]  <= do_pop ? rd_data[2*TIME_BITS-1:TIME_BITS] :
                                    q_item.svc_ticks[TIME_BITS-1:0];
      end
    end
  end
endmodule
`default_nettype wire

[src/multi_cpu_task_dispatcher_core.sv]
// Top level: multiprocessor ready-queue task dispatcher.
// Usage:
//  - in_ beats carry arrival/departure events, time-ordered; one out_ beat per event.
//  - cfg_ beats write mode (index 0) and active CPU count (index 1); cfg_ready
//    is high only while the block is idle, with nothing in flight.
//  - A two-entry front queue accepts events while the back end works.
//  - Back end takes an event through Idle, Read and Emit: pick it up, read the
//    FIFO head RAM and form the waiting-count times elapsed-time product, then
//    apply the event and register the result.
//  - out_valid is registered and rises once the event has left the Emit state.
//  - The back end takes one event at a time: it starts the next event only
//    the cycle after the previous result beat left.
//  - A stalled receiver holds out_valid; one result plus two queued events
//    are then in flight and in_ready drops.
//  - Synchronous reset clears CPU busy bits, FIFO pointers and accumulators;
//    FIFO memory contents stay undefined and are never read before written.
//  - Times are masked to the time width; accumulators saturate.
`default_nettype none
module multi_cpu_task_dispatcher_core #(
  parameter int QUEUE_DEPTH = mctd_pkg::QueueDepthDef
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mctd_if.sink       in_ch,
  mctd_if.source     out_ch,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);
  logic       mode_r;
  logic [3:0] active_r;
  logic       q_valid, q_pop, idle;
  mctd_pkg::in_item_t q_item;

  assign cfg_ready = idle;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      active_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mctd_pkg::RegMode:   mode_r   <= cfg_data[0];
        mctd_pkg::RegActive: active_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mctd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  mctd_back #(.QUEUE_DEPTH(QUEUE_DEPTH))
  u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r), .active(active_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_ch(out_ch), .idle(idle)
  );

  // result stays up while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  // a pop only happens with an item present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  // idle implies no pending result
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    idle |-> !out_ch.valid) else $error("idle with result pending");
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench: self-checking random and directed test of the task dispatcher core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int FifoDepth  = 16;

  // One queued or running task.
  typedef struct {
    bit [15:0] tid;
    bit [31:0] arr;
    bit [31:0] svc;
  } job_t;

  // Dispatcher predictor plus the queue of results it expects.
  class dispatch_scoreboard;
    bit        mode;
    bit [3:0]  active;
    bit [7:0]  busy;
    job_t      running[8];
    job_t      ready_q[9][$];
    int        waiting;
    bit [31:0] prev_time;
    bit [31:0] done_cnt;
    bit [47:0] turn_acc;
    bit [47:0] busy_acc;
    bit [63:0] area_acc;
    mctd_pkg::out_item_t expected_results[$];
    int        mismatches;

    function new();
      mode = 0;
      active = 8;
      busy = '0;
      waiting = 0;
      prev_time = '0;
      done_cnt = '0;
      turn_acc = '0;
      busy_acc = '0;
      area_acc = '0;
      mismatches = 0;
    endfunction

    function int cpus_used();
      if (active == 0) return 1;
      if (active > 8) return 8;
      return active;
    endfunction

    function void configure(bit idx, bit [3:0] val);
      if (idx == mctd_pkg::RegMode) mode = val[0];
      else active = val;
    endfunction

    function bit [47:0] add48(bit [47:0] a, bit [47:0] b);
      bit [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? mctd_pkg::Acc48Max : s[47:0];
    endfunction

    function void dispatch(int c, job_t j, bit [31:0] now, ref mctd_pkg::out_item_t r);
      busy[c] = 1'b1;
      running[c] = j;
      r.started = 1'b1;
      r.start_cpu = c[2:0];
      r.start_task = j.tid;
      r.departure_due = {1'b0, now} + {1'b0, j.svc};
    endfunction

    function void push_job(int q, job_t j, ref mctd_pkg::out_item_t r);
      if (ready_q[q].size() >= FifoDepth) begin
        r.status = mctd_pkg::StFull;
      end else begin
        ready_q[q].insert(ready_q[q].size(), j);
        waiting++;
      end
    endfunction

    // Apply one accepted event and queue its expected result beat.
    function void note_event(mctd_pkg::in_item_t e);
      mctd_pkg::out_item_t r;
      int        n, w, found;
      bit [31:0] dt, ta;
      bit [64:0] sum;
      job_t      j;
      r = '0;
      n = cpus_used();
      w = 0;
      if (mode) w = ready_q[8].size();
      else for (int i = 0; i < 8; i++) w += ready_q[i].size();
      dt = (e.event_time > prev_time) ? e.event_time - prev_time : 32'd0;
      sum = {1'b0, area_acc} + 65'(w) * 65'(dt);
      area_acc = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      prev_time = e.event_time;
      j.tid = e.task_id;
      j.arr = e.event_time;
      j.svc = e.svc_ticks;
      if (e.opcode == mctd_pkg::OpArrival) begin
        if (!mode) begin
          if (e.target_cpu >= n) r.status = mctd_pkg::StBadCpu;
          else if (!busy[e.target_cpu]) dispatch(e.target_cpu, j, e.event_time, r);
          else push_job(e.target_cpu, j, r);
        end else begin
          found = n;
          for (int i = n - 1; i >= 0; i--) if (!busy[i]) found = i;
          if (found < n) dispatch(found, j, e.event_time, r);
          else push_job(8, j, r);
        end
      end else if (e.cpu_index >= n) begin
        r.status = mctd_pkg::StBadCpu;
      end else if (!busy[e.cpu_index]) begin
        r.status = mctd_pkg::StIdleDep;
      end else begin
        ta = (e.event_time > running[e.cpu_index].arr) ?
             e.event_time - running[e.cpu_index].arr : 32'd0;
        turn_acc = add48(turn_acc, 48'(ta));
        busy_acc = add48(busy_acc, 48'(running[e.cpu_index].svc));
        if (done_cnt != 32'hFFFF_FFFF) done_cnt++;
        w = mode ? 8 : e.cpu_index;
        if (ready_q[w].size() > 0) begin
          j = ready_q[w][0];
          ready_q[w].delete(0);
          waiting--;
          dispatch(e.cpu_index, j, e.event_time, r);
        end else begin
          busy[e.cpu_index] = 1'b0;
        end
      end
      r.completed_total = done_cnt;
      r.turnaround_total = turn_acc;
      r.busy_total = busy_acc;
      r.queue_area = area_acc;
      r.waiting_now = (waiting > 255) ? 8'd255 : 8'(waiting);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_result(mctd_pkg::out_item_t got);
      mctd_pkg::out_item_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp = expected_results[0];
      expected_results.delete(0);
      if (got.status !== exp.status || got.started !== exp.started ||
          got.start_cpu !== exp.start_cpu || got.start_task !== exp.start_task ||
          got.departure_due !== exp.departure_due ||
          got.completed_total !== exp.completed_total ||
          got.turnaround_total !== exp.turnaround_total ||
          got.busy_total !== exp.busy_total || got.queue_area !== exp.queue_area ||
          got.waiting_now !== exp.waiting_now) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", exp, got);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [3:0] cfg_data;

  mctd_if #(.payload_t(mctd_pkg::in_item_t))  in_ch ();
  mctd_if #(.payload_t(mctd_pkg::out_item_t)) out_ch ();

  multi_cpu_task_dispatcher_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  dispatch_scoreboard sb = new();
  bit        quiet;      // no idling on either side
  bit        hold_req;   // ask receiver for one long stall
  bit [31:0] now_t;      // running event clock
  int        cycles = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result monitor: outputs are sampled before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Receiver: random ready bursts, one long stall on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  // Offer one event beat, optionally after a gap, and log it once taken.
  task automatic send_event(mctd_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(it);
  endtask

  task automatic ev(bit op, bit [31:0] t, bit [15:0] tid, bit [31:0] svc,
                    bit [2:0] tgt, bit [2:0] cidx);
    mctd_pkg::in_item_t it;
    it.opcode = op;
    it.event_time = t;
    it.task_id = tid;
    it.svc_ticks = svc;
    it.target_cpu = tgt;
    it.cpu_index = cidx;
    send_event(it);
  endtask

  // Drain: sender stops until every expected beat is back, plus back-end slack.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random event; departures mostly hit busy CPUs so queues get drained.
  task automatic random_event();
    mctd_pkg::in_item_t it;
    int       n, pick;
    int       cands[$];
    n = sb.cpus_used();
    case ($urandom_range(0, 39))
      0:       now_t = now_t - $urandom_range(1, 100);   // time goes backwards
      1:       now_t = now_t + $urandom;
      default: now_t = now_t + $urandom_range(0, 50);
    endcase
    it.opcode = ($urandom_range(0, 99) < 55) ? mctd_pkg::OpArrival : mctd_pkg::OpDeparture;
    it.event_time = now_t;
    it.task_id = 16'($urandom);
    it.svc_ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
    it.target_cpu = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, n - 1)) :
                    3'($urandom_range(0, 7));
    it.cpu_index = 3'($urandom_range(0, 7));
    for (int i = 0; i < n; i++) if (sb.busy[i]) cands.insert(cands.size(), i);
    if (cands.size() > 0 && $urandom_range(0, 3) != 0) begin
      pick = cands[$urandom_range(0, cands.size() - 1)];
      it.cpu_index = pick[2:0];
    end
    send_event(it);
  endtask

  initial begin
    bit [4:0] plan[8];
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = mctd_pkg::RegMode;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of fields, idle departure, queueing per CPU.
    ev(mctd_pkg::OpArrival, 32'd0, 16'h0000, 32'd0, 3'd0, 3'd7);
    ev(mctd_pkg::OpArrival, 32'd5, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, 3'd0);
    ev(mctd_pkg::OpArrival, 32'd9, 16'h1234, 32'd20, 3'd0, 3'd0);
    ev(mctd_pkg::OpArrival, 32'd9, 16'h4321, 32'd7, 3'd7, 3'd0);
    ev(mctd_pkg::OpDeparture, 32'd30, 16'h0, 32'd0, 3'd0, 3'd0);
    ev(mctd_pkg::OpDeparture, 32'd50, 16'h0, 32'd0, 3'd0, 3'd0);
    ev(mctd_pkg::OpDeparture, 32'd51, 16'h0, 32'd0, 3'd0, 3'd0);   // idle CPU
    ev(mctd_pkg::OpDeparture, 32'd40, 16'h0, 32'd0, 3'd0, 3'd3);   // backwards, idle
    drain();
    // Fewer CPUs: out-of-range target and departure CPU.
    write_reg(mctd_pkg::RegActive, 4'd2);
    ev(mctd_pkg::OpArrival, 32'd60, 16'h00AA, 32'd3, 3'd5, 3'd0);
    ev(mctd_pkg::OpDeparture, 32'd61, 16'h0, 32'd0, 3'd0, 3'd6);
    drain();
    // Shared queue; per-CPU leftovers on CPU 7 stay counted.
    write_reg(mctd_pkg::RegMode, 4'd1);
    ev(mctd_pkg::OpArrival, 32'd70, 16'h0101, 32'd10, 3'd0, 3'd0);
    ev(mctd_pkg::OpArrival, 32'd71, 16'h0202, 32'd10, 3'd0, 3'd0);
    ev(mctd_pkg::OpArrival, 32'd72, 16'h0303, 32'd10, 3'd0, 3'd0);
    ev(mctd_pkg::OpDeparture, 32'd80, 16'h0, 32'd0, 3'd0, 3'd1);
    ev(mctd_pkg::OpDeparture, 32'hFFFF_FFF0, 16'h0, 32'd0, 3'd0, 3'd0);
    ev(mctd_pkg::OpArrival, 32'hFFFF_FFFF, 16'h0404, 32'hFFFF_FFFF, 3'd0, 3'd0);
    now_t = 32'd100;   // wraps to small times: elapsed counts as zero
    drain();

    // Random phases: {mode, active}; both modes and CPU counts of 1 and 8 included.
    plan = '{5'b0_1000, 5'b1_1000, 5'b0_0001, 5'b1_0001,
             5'b1_0011, 5'b0_0101, 5'b0_1000, 5'b1_0100};
    foreach (plan[p]) begin
      write_reg(mctd_pkg::RegMode, {3'd0, plan[p][4]});
      write_reg(mctd_pkg::RegActive, plan[p][3:0]);
      if (p == 6) hold_req = 1'b1;   // receiver stalls long, input backs up
      if (p == 7) quiet = 1'b1;      // final stretch without idling
      repeat (65) random_event();
      drain();
    end

    repeat (20) @(posedge clk);
    sb.mismatches += sb.expected_results.size();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
